// File: rtl/perspective_coordinate_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the perspective coordinate mapper
// shared implication forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_COORDINATE_MAPPER_CORE_ASSERT_SVH
`define PERSPECTIVE_COORDINATE_MAPPER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define PCM_ASSERT_LATER(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// constants, register indexes and stage control type of the coordinate mapper
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int MAX_IMAGE_DIM   = 4096;
    localparam int COORD_FRAC_BITS = 8;
    localparam int Q_BITS          = 20;  // quotient bits that can ever be valid
    localparam int SUM_W           = 47;
    localparam int MAG_W           = 47;
    localparam int NUM_W           = MAG_W + COORD_FRAC_BITS;
    localparam int CMP_W           = MAG_W + Q_BITS + 1;
    localparam int OUT_W           = 21;
    // products, sums, magnitudes, overflow check, quotient bits, output
    localparam int LATENCY         = 4 + Q_BITS + 1;

    localparam logic [3:0] REG_PERSP_EN  = 4'd0;
    localparam logic [3:0] REG_IN_WIDTH  = 4'd1;
    localparam logic [3:0] REG_IN_HEIGHT = 4'd2;
    localparam logic [3:0] REG_COEF_A    = 4'd3;
    localparam logic [3:0] REG_COEF_B    = 4'd4;
    localparam logic [3:0] REG_COEF_C    = 4'd5;
    localparam logic [3:0] REG_COEF_D    = 4'd6;
    localparam logic [3:0] REG_COEF_LAST = 4'd7;

    localparam logic signed [OUT_W-1:0] INVALID_COORD =
        -(OUT_W'(1) <<< COORD_FRAC_BITS);

    typedef struct packed {
        logic        vld;
        logic        persp;
        logic [11:0] x;
        logic [11:0] y;
        logic        bad;   // zero denominator, wrong sign or quotient overflow
    } t_ctl;

endpackage

// File: rtl/perspective_coordinate_mapper_core.sv
// ----------------------------------------------------------------------------
// perspective_coordinate_mapper_core
// maps an output pixel to its source position through a 3x3 homography
// ----------------------------------------------------------------------------
// One pixel is taken on every clock at which start is high; busy stays low, so
// the block never refuses a pixel. Each result leaves on o_strobe for a single
// cycle and cannot be held off. The pipeline depth is set by the pipelined
// restoring divider: one quotient bit per stage for the 20 bits a valid Q12.8
// source can have, behind products, sums, magnitudes and an overflow check.
// Configuration writes take effect at once and are meant for an idle pipeline.
module perspective_coordinate_mapper_core import pcm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [11:0]             i_pixel_x,
    input  logic [11:0]             i_pixel_y,
    input  logic                    i_cfg_we,
    input  logic [3:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    output logic                    o_strobe,
    output logic signed [OUT_W-1:0] o_source_x,
    output logic signed [OUT_W-1:0] o_source_y,
    output logic                    o_map_valid
);

    // configuration registers
    logic        r_persp_en;
    logic [12:0] r_in_width;
    logic [12:0] r_in_height;
    logic [63:0] r_coef_a;
    logic [63:0] r_coef_b;
    logic [63:0] r_coef_c;
    logic [63:0] r_coef_d;
    logic [31:0] r_coef_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persp_en  <= 1'b0;
            r_in_width  <= 13'd640;
            r_in_height <= 13'd480;
            r_coef_a    <= '0;
            r_coef_b    <= '0;
            r_coef_c    <= '0;
            r_coef_d    <= '0;
            r_coef_last <= 32'd1048576;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PERSP_EN:  r_persp_en  <= i_cfg_data[0];
                REG_IN_WIDTH:  r_in_width  <= i_cfg_data[12:0];
                REG_IN_HEIGHT: r_in_height <= i_cfg_data[12:0];
                REG_COEF_A:    r_coef_a    <= i_cfg_data;
                REG_COEF_B:    r_coef_b    <= i_cfg_data;
                REG_COEF_C:    r_coef_c    <= i_cfg_data;
                REG_COEF_D:    r_coef_d    <= i_cfg_data;
                REG_COEF_LAST: r_coef_last <= i_cfg_data[31:0];
                default: ; // indexes past the list are ignored
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: six coefficient products, pixel taken as positive 13-bit
    logic signed [12:0] w_xs, w_ys;
    assign w_xs = signed'({1'b0, i_pixel_x});
    assign w_ys = signed'({1'b0, i_pixel_y});

    logic signed [44:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    t_ctl               r_ctl1;
    always_ff @(posedge i_clk) begin
        r_p00 <= signed'(r_coef_a[63:32]) * w_xs;
        r_p01 <= signed'(r_coef_a[31:0])  * w_ys;
        r_p10 <= signed'(r_coef_b[31:0])  * w_xs;
        r_p11 <= signed'(r_coef_c[63:32]) * w_ys;
        r_p20 <= signed'(r_coef_d[63:32]) * w_xs;
        r_p21 <= signed'(r_coef_d[31:0])  * w_ys;
        r_ctl1.persp <= r_persp_en;
        r_ctl1.x     <= i_pixel_x;
        r_ctl1.y     <= i_pixel_y;
        r_ctl1.bad   <= 1'b0;
        if (!i_rst_n) begin
            r_ctl1.vld <= 1'b0;
        end else begin
            r_ctl1.vld <= start;
        end
    end

    // stage 2: the three dot products
    logic signed [SUM_W-1:0] r_nx, r_ny, r_den;
    t_ctl                    r_ctl2;
    always_ff @(posedge i_clk) begin
        r_nx  <= SUM_W'(r_p00) + SUM_W'(r_p01) + SUM_W'(signed'(r_coef_b[63:32]));
        r_ny  <= SUM_W'(r_p10) + SUM_W'(r_p11) + SUM_W'(signed'(r_coef_c[31:0]));
        r_den <= SUM_W'(r_p20) + SUM_W'(r_p21) + SUM_W'(signed'(r_coef_last));
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= r_ctl1;
        end
    end

    // stage 3: magnitudes and sign checks, numerators scaled to Q.8
    logic [MAG_W-1:0] w_mnx, w_mny, w_mden;
    logic             w_negx, w_negy;
    assign w_mnx  = r_nx[SUM_W-1]  ? MAG_W'(-r_nx)  : MAG_W'(r_nx);
    assign w_mny  = r_ny[SUM_W-1]  ? MAG_W'(-r_ny)  : MAG_W'(r_ny);
    assign w_mden = r_den[SUM_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
    assign w_negx = (r_nx != '0) && (r_nx[SUM_W-1] != r_den[SUM_W-1]);
    assign w_negy = (r_ny != '0) && (r_ny[SUM_W-1] != r_den[SUM_W-1]);

    logic [NUM_W-1:0] r_ax, r_ay;
    logic [MAG_W-1:0] r_b3;
    t_ctl             r_ctl3;
    always_ff @(posedge i_clk) begin
        r_ax   <= {w_mnx, {COORD_FRAC_BITS{1'b0}}};
        r_ay   <= {w_mny, {COORD_FRAC_BITS{1'b0}}};
        r_b3   <= w_mden;
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else begin
            r_ctl3 <= '{vld: r_ctl2.vld, persp: r_ctl2.persp, x: r_ctl2.x, y: r_ctl2.y,
                        bad: (r_den == '0) || w_negx || w_negy};
        end
    end

    // divider chain: index 0 is the overflow check, then one quotient bit each
    logic [NUM_W-1:0]  r_remx [0:Q_BITS];
    logic [NUM_W-1:0]  r_remy [0:Q_BITS];
    logic [Q_BITS-1:0] r_qx   [0:Q_BITS];
    logic [Q_BITS-1:0] r_qy   [0:Q_BITS];
    logic [MAG_W-1:0]  r_b    [0:Q_BITS];
    t_ctl              r_ctl  [0:Q_BITS];

    always_ff @(posedge i_clk) begin
        r_remx[0] <= r_ax;
        r_remy[0] <= r_ay;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_b[0]    <= r_b3;
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            // a quotient of 2^20 or more is never inside the image
            r_ctl[0] <= '{vld: r_ctl3.vld, persp: r_ctl3.persp, x: r_ctl3.x, y: r_ctl3.y,
                          bad: r_ctl3.bad
                               || (CMP_W'(r_ax) >= (CMP_W'(r_b3) << Q_BITS))
                               || (CMP_W'(r_ay) >= (CMP_W'(r_b3) << Q_BITS))};
        end
    end

    for (genvar j = 1; j <= Q_BITS; j++) begin : g_div
        localparam int SH = Q_BITS - j;
        logic [CMP_W-1:0] w_dv;
        logic             w_gex, w_gey;
        assign w_dv  = CMP_W'(r_b[j-1]) << SH;
        assign w_gex = CMP_W'(r_remx[j-1]) >= w_dv;
        assign w_gey = CMP_W'(r_remy[j-1]) >= w_dv;

        always_ff @(posedge i_clk) begin
            r_remx[j] <= w_gex ? NUM_W'(CMP_W'(r_remx[j-1]) - w_dv) : r_remx[j-1];
            r_remy[j] <= w_gey ? NUM_W'(CMP_W'(r_remy[j-1]) - w_dv) : r_remy[j-1];
            r_qx[j]   <= r_qx[j-1] | (Q_BITS'(w_gex) << SH);
            r_qy[j]   <= r_qy[j-1] | (Q_BITS'(w_gey) << SH);
            r_b[j]    <= r_b[j-1];
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    // output stage: range check against the clamped image size
    logic [12:0] w_wl, w_hl;
    logic [20:0] w_bndx, w_bndy;
    logic        w_pok, w_iok, w_ok;
    t_ctl        w_cf;
    assign w_cf   = r_ctl[Q_BITS];
    assign w_wl   = (r_in_width  > 13'(MAX_IMAGE_DIM)) ? 13'(MAX_IMAGE_DIM) : r_in_width;
    assign w_hl   = (r_in_height > 13'(MAX_IMAGE_DIM)) ? 13'(MAX_IMAGE_DIM) : r_in_height;
    assign w_bndx = 21'(w_wl - 13'd1) << COORD_FRAC_BITS;
    assign w_bndy = 21'(w_hl - 13'd1) << COORD_FRAC_BITS;
    assign w_pok  = !w_cf.bad && (w_wl != '0) && (w_hl != '0)
                    && (21'(r_qx[Q_BITS]) < w_bndx) && (21'(r_qy[Q_BITS]) < w_bndy);
    assign w_iok  = (13'(w_cf.x) < r_in_width) && (13'(w_cf.y) < r_in_height);
    assign w_ok   = w_cf.persp ? w_pok : w_iok;

    logic                    r_strobe;
    logic signed [OUT_W-1:0] r_sx, r_sy;
    logic                    r_ok;
    always_ff @(posedge i_clk) begin
        if (!w_ok) begin
            r_sx <= INVALID_COORD;
            r_sy <= INVALID_COORD;
        end else if (w_cf.persp) begin
            r_sx <= signed'(OUT_W'(r_qx[Q_BITS]));
            r_sy <= signed'(OUT_W'(r_qy[Q_BITS]));
        end else begin
            r_sx <= signed'(OUT_W'(w_cf.x) << COORD_FRAC_BITS);
            r_sy <= signed'(OUT_W'(w_cf.y) << COORD_FRAC_BITS);
        end
        r_ok <= w_ok;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_cf.vld;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_source_x  = r_sx;
    assign o_source_y  = r_sy;
    assign o_map_valid = r_ok;

endmodule

// File: rtl/pcm_checker.sv
// ----------------------------------------------------------------------------
// pcm_checker
// port-level checks on transfer timing and invalid result coding
// ----------------------------------------------------------------------------
`include "perspective_coordinate_mapper_core_assert.svh"

module pcm_checker import pcm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_strobe,
    input logic signed [OUT_W-1:0] o_source_x,
    input logic signed [OUT_W-1:0] o_source_y,
    input logic                    o_map_valid
);

    `PCM_ASSERT_LATER(a_result_follows, i_clk, i_rst_n, start && !busy, LATENCY, o_strobe)
    `PCM_ASSERT_LATER(a_no_spurious, i_clk, i_rst_n, !(start && !busy), LATENCY, !o_strobe)
    `PCM_ASSERT_NOW(a_invalid_code, i_clk, i_rst_n, o_strobe && !o_map_valid, (o_source_x == INVALID_COORD) && (o_source_y == INVALID_COORD))
    `PCM_ASSERT_NOW(a_valid_positive, i_clk, i_rst_n, o_strobe && o_map_valid, !o_source_x[OUT_W-1] && !o_source_y[OUT_W-1])

endmodule

bind perspective_coordinate_mapper_core pcm_checker u_pcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_source_x  (o_source_x),
    .o_source_y  (o_source_y),
    .o_map_valid (o_map_valid)
);

// File: tb/tb_perspective_coordinate_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_perspective_coordinate_mapper_core
// self-checking bench for the perspective coordinate mapper: an in-bench
// homography model predicts each pixel transfer, results are checked in order
// ----------------------------------------------------------------------------
module tb_perspective_coordinate_mapper_core;
    import pcm_pkg::*;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
    } t_pixel;

    typedef struct packed {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic             vld;
    } t_source;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] i_pixel_x = '0;
    logic [11:0] i_pixel_y = '0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic                    o_strobe;
    logic signed [OUT_W-1:0] o_source_x;
    logic signed [OUT_W-1:0] o_source_y;
    logic                    o_map_valid;

    perspective_coordinate_mapper_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_source_x  (o_source_x),
        .o_source_y  (o_source_y),
        .o_map_valid (o_map_valid)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the register file
    logic        sh_persp  = 1'b0;
    logic [12:0] sh_width  = 13'd640;
    logic [12:0] sh_height = 13'd480;
    logic [63:0] sh_coef_a = '0;
    logic [63:0] sh_coef_b = '0;
    logic [63:0] sh_coef_c = '0;
    logic [63:0] sh_coef_d = '0;
    logic [31:0] sh_coef_last = 32'd1048576;

    t_pixel  pixel_queue[$];
    t_source source_queue[$];
    int      mismatches = 0;
    bit      no_idle = 1'b0;
    int      stall_cycles = 0;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // truncating quotient and its range check against the clamped size
    function automatic bit divide_in_range(longint num, longint den,
                                           longint unsigned dim, output longint q);
        longint unsigned qm;
        bit              neg;
        qm  = (magnitude(num) << COORD_FRAC_BITS) / magnitude(den);
        neg = (num != 0) && ((num < 0) != (den < 0));
        q   = neg ? -longint'(qm) : longint'(qm);
        if (neg || dim == 0)
            return 1'b0;
        return q < ((longint'(dim) - 1) <<< COORD_FRAC_BITS);
    endfunction

    function automatic t_source map_pixel(t_pixel p);
        longint          x, y, nx, ny, dn, rx, ry;
        longint unsigned w, h;
        bit              ok, okx, oky;
        t_source         r;
        x  = longint'(p.x);
        y  = longint'(p.y);
        w  = (sh_width  > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : sh_width;
        h  = (sh_height > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : sh_height;
        rx = 0;
        ry = 0;
        if (sh_persp) begin
            nx = longint'($signed(sh_coef_a[63:32])) * x
               + longint'($signed(sh_coef_a[31:0])) * y + longint'($signed(sh_coef_b[63:32]));
            ny = longint'($signed(sh_coef_b[31:0])) * x
               + longint'($signed(sh_coef_c[63:32])) * y + longint'($signed(sh_coef_c[31:0]));
            dn = longint'($signed(sh_coef_d[63:32])) * x
               + longint'($signed(sh_coef_d[31:0])) * y + longint'($signed(sh_coef_last));
            if (dn == 0) begin
                ok = 1'b0;
            end else begin
                okx = divide_in_range(nx, dn, w, rx);
                oky = divide_in_range(ny, dn, h, ry);
                ok  = okx && oky;
            end
        end else begin
            ok = (x < w) && (y < h);
            rx = x <<< COORD_FRAC_BITS;
            ry = y <<< COORD_FRAC_BITS;
        end
        if (!ok) begin
            rx = -(longint'(1) <<< COORD_FRAC_BITS);
            ry = rx;
        end
        r.sx  = rx[OUT_W-1:0];
        r.sy  = ry[OUT_W-1:0];
        r.vld = ok;
        return r;
    endfunction

    // driver: start stays high across back-to-back transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                source_queue.push_back(map_pixel('{x: i_pixel_x, y: i_pixel_y}));
            if (!start || !busy) begin
                if (pixel_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
                    start     <= 1'b1;
                    i_pixel_x <= pixel_queue[0].x;
                    i_pixel_y <= pixel_queue[0].y;
                    void'(pixel_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (source_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: x=%0d y=%0d valid=%0b",
                                 o_source_x, o_source_y, o_map_valid);
                end else begin
                    if (o_source_x !== source_queue[0].sx || o_source_y !== source_queue[0].sy
                            || o_map_valid !== source_queue[0].vld) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
                                     $signed(source_queue[0].sx), $signed(source_queue[0].sy),
                                     source_queue[0].vld, o_source_x, o_source_y, o_map_valid);
                    end
                    void'(source_queue.pop_front());
                end
            end
            if (o_strobe || (start && !busy) || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_PERSP_EN:  sh_persp     = val[0];
            REG_IN_WIDTH:  sh_width     = val[12:0];
            REG_IN_HEIGHT: sh_height    = val[12:0];
            REG_COEF_A:    sh_coef_a    = val;
            REG_COEF_B:    sh_coef_b    = val;
            REG_COEF_C:    sh_coef_c    = val;
            REG_COEF_D:    sh_coef_d    = val;
            REG_COEF_LAST: sh_coef_last = val[31:0];
            default: ;  // beyond the register list, ignored
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the pipe to drain before touching registers
    task automatic drain;
        while (pixel_queue.size() > 0 || start || source_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] spread(int unsigned span);
        return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endfunction

    task automatic push_pixel(input logic [11:0] x, input logic [11:0] y);
        pixel_queue.push_back('{x: x, y: y});
    endtask

    // well-behaved homography with random content
    task automatic load_plausible_homography;
        logic [31:0] m00, m11;
        m00 = 32'($urandom_range(1 << 18, 1 << 21));
        m11 = 32'($urandom_range(1 << 18, 1 << 21));
        write_reg(REG_COEF_A, {m00, spread(1 << 16)});
        write_reg(REG_COEF_B, {spread(64 << 20), spread(1 << 16)});
        write_reg(REG_COEF_C, {m11, spread(64 << 20)});
        write_reg(REG_COEF_D, {spread(1 << 9), spread(1 << 9)});
        write_reg(REG_COEF_LAST, {32'd0, 32'(1 << 20) + spread(1 << 16)});
    endtask

    initial begin
        int kind;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity at reset settings, edges of the image and of the fields
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd639, 12'd479);
        push_pixel(12'd640, 12'd0);
        push_pixel(12'd0, 12'd480);
        drain();

        // unit homography, then zero denominator, then negative denominator
        write_reg(REG_PERSP_EN, 64'd1);
        write_reg(REG_COEF_A, {32'd1048576, 32'd0});
        write_reg(REG_COEF_C, {32'd1048576, 32'd0});
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd638, 12'd478);
        push_pixel(12'd639, 12'd10);
        push_pixel(12'd4095, 12'd4095);
        drain();
        write_reg(REG_COEF_LAST, 64'd0);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd5, 12'd5);
        drain();
        write_reg(REG_COEF_LAST, {32'd0, 32'hFFF0_0000});
        push_pixel(12'd5, 12'd5);
        push_pixel(12'd0, 12'd0);
        drain();

        // zero size, oversize clamp, ignored index
        write_reg(REG_COEF_LAST, {32'd0, 32'd1048576});
        write_reg(REG_IN_WIDTH, 64'd0);
        push_pixel(12'd1, 12'd1);
        drain();
        write_reg(REG_IN_WIDTH, 64'h1FFF);
        write_reg(REG_IN_HEIGHT, 64'd8191);
        write_reg(4'd12, 64'hFFFF_FFFF_FFFF_FFFF);
        push_pixel(12'd4094, 12'd4094);
        push_pixel(12'd4095, 12'd3000);
        drain();
        write_reg(REG_PERSP_EN, 64'd0);
        drain();
        push_pixel(12'd4095, 12'd4095);
        drain();
        write_reg(REG_IN_HEIGHT, 64'd1);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd0, 12'd1);
        drain();

        // random phases, one of them with no idling at all
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            kind = $urandom_range(0, 9);
            no_idle = (ph == 4);
            write_reg(REG_PERSP_EN, {63'd0, kind != 0});
            case ($urandom_range(0, 4))
                0:       write_reg(REG_IN_WIDTH, 64'd1);
                1:       write_reg(REG_IN_WIDTH, 64'd4096);
                2:       write_reg(REG_IN_WIDTH, 64'($urandom_range(4097, 8191)));
                default: write_reg(REG_IN_WIDTH, 64'($urandom_range(2, 4096)));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_IN_HEIGHT, 64'd0);
                1:       write_reg(REG_IN_HEIGHT, 64'd4096);
                2:       write_reg(REG_IN_HEIGHT, 64'($urandom_range(4097, 8191)));
                default: write_reg(REG_IN_HEIGHT, 64'($urandom_range(2, 4096)));
            endcase
            if (kind >= 8) begin
                // fully random coefficients, all bits exercised
                write_reg(REG_COEF_A, {$urandom, $urandom});
                write_reg(REG_COEF_B, {$urandom, $urandom});
                write_reg(REG_COEF_C, {$urandom, $urandom});
                write_reg(REG_COEF_D, {$urandom, $urandom});
                write_reg(REG_COEF_LAST, {$urandom, $urandom});
            end else if (kind == 7) begin
                // extreme coefficients
                write_reg(REG_COEF_A, {32'h7FFF_FFFF, 32'h8000_0000});
                write_reg(REG_COEF_B, {32'h8000_0000, 32'h7FFF_FFFF});
                write_reg(REG_COEF_C, {32'hFFFF_FFFF, 32'h7FFF_FFFF});
                write_reg(REG_COEF_D, {32'd0, 32'hFFFF_FFFF});
                write_reg(REG_COEF_LAST, {32'hFFFF_FFFF, 32'h8000_0000});
            end else begin
                load_plausible_homography();
            end
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 1))
                    push_pixel(12'($urandom), 12'($urandom));
                else
                    push_pixel(12'($urandom_range(0, 1023)), 12'($urandom_range(0, 767)));
            end
        end
        no_idle = 1'b0;
        drain();

        if (mismatches == 0 && source_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
